// ===== hw/rtl/mbp_pkg.sv =====
// Shared types and constants for the MSB-first bit packer.
package mbp_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 64;
    localparam int LEN_W   = 7;
    localparam int PART_W  = 7;
    localparam int CNT_W   = 3;
    localparam int WORD_W  = CODE_W + BYTE_W;
    localparam int NRES_W  = 4;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_FLUSH  = 2'd1,
        REQ_RESET  = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;  // take the input item this cycle
        logic emit;    // move the next byte into the output register
        logic last;    // the emitted byte is the final one of the item
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [NRES_W-1:0] results;   // results the current input item yields
        logic              out_free;  // output register can take a byte
    } t_stat;

endpackage

// ===== hw/rtl/mbp_ctrl.sv =====
// Controller: accepts an item, then sequences its output bytes.
module mbp_ctrl
    import mbp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state            r_state, n_state;
    logic [NRES_W-1:0] r_left,  n_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && (i_stat.results != '0)) begin
                    n_state = ST_EMIT;
                    n_left  = i_stat.results;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_left = r_left - NRES_W'(1);
                    if (r_left == NRES_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready      = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = 1'b0;
        o_cmd.last   = (r_left == NRES_W'(1));
        case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/mbp_datapath.sv =====
// Datapath: bit buffer, byte shift register and output register.
module mbp_datapath
    import mbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [1:0]         i_req,
    input  logic [CODE_W-1:0]  i_code,
    input  logic [LEN_W-1:0]   i_len,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [BYTE_W-1:0]  o_byte,
    output logic               o_present,
    output logic [CNT_W-1:0]   o_pad,
    output logic               o_last
);

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_CODE_LEN);

    t_req                req;
    logic [PART_W-1:0]   r_partial;
    logic [CNT_W-1:0]    r_cnt;
    logic [WORD_W-1:0]   r_word;
    logic [CNT_W-1:0]    r_pad;
    logic                r_present;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_present;
    logic [CNT_W-1:0]    r_out_pad;
    logic                r_out_last;

    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    total;
    logic [NRES_W-1:0]   nbytes;
    logic [CNT_W-1:0]    rem;
    logic [CODE_W-1:0]   code_al;
    logic [BYTE_W-1:0]   part_al;
    logic [WORD_W-1:0]   wr_word;
    logic [PART_W-1:0]   part_low;
    logic [PART_W-1:0]   code_mask;
    logic [PART_W-1:0]   rem_mask;
    logic [PART_W-1:0]   wr_partial;

    assign req = t_req'(i_req);

    // bit arithmetic for the offered item
    always_comb begin
        len       = (i_len > MaxLen) ? MaxLen : i_len;
        total     = len + LEN_W'(r_cnt);
        nbytes    = total[LEN_W-1:3];
        rem       = total[2:0];
        // code bits left aligned, kept bits left aligned in a byte
        code_al   = i_code << (LEN_W'(CODE_W) - len);
        part_al   = BYTE_W'({1'b0, r_partial} << (4'd8 - {1'b0, r_cnt}));
        wr_word   = {part_al, {CODE_W{1'b0}}} | ({code_al, {BYTE_W{1'b0}}} >> r_cnt);
        // trailing bits that stay buffered after the whole bytes go out
        part_low  = (len >= LEN_W'(PART_W)) ? '0 : PART_W'(r_partial << len[2:0]);
        code_mask = (len >= LEN_W'(PART_W)) ? '1 : PART_W'((8'd1 << len[2:0]) - 8'd1);
        rem_mask  = PART_W'((8'd1 << rem) - 8'd1);
        wr_partial = (part_low | (i_code[PART_W-1:0] & code_mask)) & rem_mask;
    end

    always_comb begin
        case (req)
            REQ_WRITE: o_stat.results = nbytes;
            REQ_FLUSH: o_stat.results = NRES_W'(1);
            default:   o_stat.results = '0;
        endcase
        o_stat.out_free = !r_out_valid || i_ready;
    end

    // buffered bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_cnt     <= '0;
        end else if (i_cmd.accept) begin
            case (req)
                REQ_WRITE: begin
                    r_partial <= wr_partial;
                    r_cnt     <= rem;
                end
                REQ_FLUSH, REQ_RESET: begin
                    r_partial <= '0;
                    r_cnt     <= '0;
                end
                default: begin
                    r_partial <= r_partial;
                    r_cnt     <= r_cnt;
                end
            endcase
        end
    end

    // byte shift register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (req == REQ_FLUSH) begin
                r_word    <= {part_al, {CODE_W{1'b0}}};
                r_pad     <= CNT_W'(0) - r_cnt;
                r_present <= (r_cnt != '0);
            end else begin
                r_word    <= wr_word;
                r_pad     <= '0;
                r_present <= 1'b1;
            end
        end else if (i_cmd.emit) begin
            r_word <= r_word << BYTE_W;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte    <= r_word[WORD_W-1 -: BYTE_W];
            r_out_present <= r_present;
            r_out_pad     <= r_pad;
            r_out_last    <= i_cmd.last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_byte    = r_out_byte;
    assign o_present = r_out_present;
    assign o_pad     = r_out_pad;
    assign o_last    = r_out_last;

endmodule

// ===== hw/rtl/msb_first_bit_packer.sv =====
// Top level of the MSB-first bit packer: stream ports, controller, datapath.
//
// Packs codes of 0 to MAX_CODE_LEN bits, most significant bit first, into
// bytes. Up to seven leftover bits are held between items. Request kinds on
// s_tuser: write appends code_len bits of code_bits and outputs each byte it
// completes (last one marked by m_tlast); flush pads the held bits with low
// zeros and outputs that byte with its pad count, or an empty result
// (m_tuser low) if nothing is held; reset clears the held bits silently;
// the unused kind is ignored. Code lengths above MAX_CODE_LEN saturate.
// Timing: an item is taken while the block is idle, then its results leave
// one byte per cycle, while m_tready allows, through a single output
// register fed from a 72-bit shift register; a flush yields one result and
// a reset none. A new item is taken as soon as the last byte of the previous
// one sits in the output register. No clearing pass after reset.
module msb_first_bit_packer
    import mbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] code_bits, [70:64] code_len, [71] zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] pad_count, [15:11] zero
    output logic        m_tuser,   // [0] byte_present
    output logic        m_tlast
);

    t_cmd             cmd;
    t_stat            stat;
    logic [BYTE_W-1:0] out_byte;
    logic [CNT_W-1:0]  out_pad;

    mbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mbp_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_req     (s_tuser),
        .i_code    (s_tdata[CODE_W-1:0]),
        .i_len     (s_tdata[CODE_W +: LEN_W]),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_byte    (out_byte),
        .o_present (m_tuser),
        .o_pad     (out_pad),
        .o_last    (m_tlast)
    );

    assign m_tdata = {5'd0, out_pad, out_byte};

    // an empty flush result carries no byte, no padding and ends its item
    a_empty_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && out_byte == '0 && out_pad == '0))
        else $error("empty flush result malformed");

    // padding only ever appears on the single, final flush result
    a_pad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && out_pad != '0) |-> m_tlast)
        else $error("padded byte not marked last");

    // reset and unused requests produce nothing and leave the block idle
    a_silent_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_RESET || s_tuser == REQ_UNUSED))
        |=> s_tready)
        else $error("silent request left block busy");

    // the controller never emits while taking an item
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.accept && cmd.emit))
        else $error("accept and emit in the same cycle");

endmodule
